### design/midi_channel_slot_allocator_unit_assert.svh
// Assertion macros for the MIDI channel slot allocator.
// Included by the top level, which checks its own logic; needs nothing else.
`ifndef MIDI_CHANNEL_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define MIDI_CHANNEL_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCSA_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCSA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/mcsa_pkg.sv
// Shared types and constants of the MIDI channel slot allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package mcsa_pkg;

   // Field widths
   localparam int ModeWidth    = 2;
   localparam int ElementWidth = 10;
   localparam int ChannelWidth = 5;
   localparam int KeyWidth     = 14;
   localparam int ValueWidth   = 14;
   localparam int KindWidth    = 2;
   localparam int SlotWidth    = 19;

   // Mapping table size and slot limits
   localparam int MaxElements    = 1024;
   localparam int EntryAddrWidth = $clog2(MaxElements);
   localparam int PlainChannels  = 16;
   localparam int NrpnSlotBits   = 18;

   typedef enum logic [ModeWidth-1:0] {
      MODE_MAP         = 2'd0,
      MODE_CLEAR_ALL   = 2'd1,
      MODE_CLEAR_TABLE = 2'd2
   } mode_type;

   typedef enum logic [KindWidth-1:0] {
      KIND_SETUP   = 2'd0,
      KIND_FORWARD = 2'd1,
      KIND_DROP    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_FORWARD
   } state_type;

   // One mapping table entry
   typedef struct packed {
      logic                    valid;
      logic [ChannelWidth-1:0] channel;
      logic [KeyWidth-1:0]     key;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic     capture;        // latch the request, read the table
      logic     commit;         // write the new entry, advance the counter
      logic     counters_reset; // rewind both allocation counters
      logic     sweep_start;    // rewind the clearing address
      logic     sweep_step;     // clear one entry, advance the address
      logic     emit;           // load a result into the output register
      kind_type emit_kind;
      logic     emit_last;
      logic     from_saved;     // take the entry saved at commit
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_map;
      logic req_clear_all;
      logic req_clear_table;
      logic fwd_ok;      // forwarding on and element in range
      logic entry_hit;   // element already mapped
      logic slot_free;   // a slot of the requested kind remains
      logic sweep_last;  // clearing address at the final entry
   } dp_status_type;

endpackage

### design/mcsa_ctrl.sv
// Sequencer of the MIDI channel slot allocator: clearing, lookup and result steps.
// Depends on mcsa_pkg; drives the datapath through ctl_cmd_type commands.
module mcsa_ctrl
   import mcsa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   state_type state_ff, state_in;

   // State register; reset starts with a sweep of the table
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               if (status.req_map) begin
                  state_in = ST_LOOKUP;
               end else if (status.req_clear_all) begin
                  cmd.counters_reset = 1'b1;
                  cmd.sweep_start    = 1'b1;
                  state_in           = ST_CLEAR;
               end else if (status.req_clear_table) begin
                  cmd.sweep_start = 1'b1;
                  state_in        = ST_CLEAR;
               end
            end
         end
         ST_LOOKUP: begin
            cmd.emit = 1'b1;
            if (!status.fwd_ok) begin
               cmd.emit_kind = KIND_DROP;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end else if (status.entry_hit) begin
               cmd.emit_kind = KIND_FORWARD;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end else if (status.slot_free) begin
               cmd.commit    = 1'b1;
               cmd.emit_kind = KIND_SETUP;
               state_in      = ST_FORWARD;
            end else begin
               cmd.emit_kind = KIND_DROP;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_FORWARD: begin
            cmd.emit       = 1'b1;
            cmd.emit_kind  = KIND_FORWARD;
            cmd.emit_last  = 1'b1;
            cmd.from_saved = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### design/mcsa_datapath.sv
// Datapath of the MIDI channel slot allocator: mapping table, counters, result register.
// Depends on mcsa_pkg; steered by mcsa_ctrl through ctl_cmd_type.
module mcsa_datapath
   import mcsa_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [ModeWidth-1:0]    req_mode,
   input  logic [ElementWidth-1:0] req_element_index,
   input  logic                    req_is_nrpn,
   input  logic [KeyWidth-1:0]     req_key_in,
   input  logic [ValueWidth-1:0]   req_value_in,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data,
   input  ctl_cmd_type             cmd,
   output dp_status_type           status,
   output logic                    rsp_strobe,
   output logic [KindWidth-1:0]    rsp_kind,
   output logic [ElementWidth-1:0] rsp_element_out,
   output logic [ChannelWidth-1:0] rsp_channel_out,
   output logic [KeyWidth-1:0]     rsp_key_out,
   output logic [ValueWidth-1:0]   rsp_value_out,
   output logic                    rsp_last
);

   entry_type mem [MaxElements];

   logic                      forward_enable_ff;
   logic [ElementWidth-1:0]   elem_ff;
   logic                      nrpn_ff;
   logic [KeyWidth-1:0]       key_ff;
   logic [ValueWidth-1:0]     value_ff;
   logic [ChannelWidth-1:0]   next_channel_ff;
   logic [SlotWidth-1:0]      next_slot_ff;
   logic [EntryAddrWidth-1:0] sweep_ff;
   entry_type                 rd_ff;
   entry_type                 saved_ff;

   logic                      rsp_strobe_ff;
   logic [KindWidth-1:0]      rsp_kind_ff;
   logic [ElementWidth-1:0]   rsp_element_ff;
   logic [ChannelWidth-1:0]   rsp_channel_ff;
   logic [KeyWidth-1:0]       rsp_key_ff;
   logic [ValueWidth-1:0]     rsp_value_ff;
   logic                      rsp_last_ff;

   logic [EntryAddrWidth-1:0] elem_addr;
   logic                      in_range;
   entry_type                 new_entry;
   entry_type                 cur_entry;
   logic                      mem_we;
   logic [EntryAddrWidth-1:0] mem_wa;
   entry_type                 mem_wd;
   logic                      slot_free;

   assign elem_addr = EntryAddrWidth'(elem_ff);
   assign in_range  = (int'(elem_ff) < MaxElements);

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         forward_enable_ff <= 1'b0;
      end else if (csr_write_enable) begin
         forward_enable_ff <= csr_write_data;
      end
   end

   // Hold the accepted request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         elem_ff  <= req_element_index;
         nrpn_ff  <= req_is_nrpn;
         key_ff   <= req_key_in;
         value_ff <= req_value_in;
      end
   end

   // Entry that a first use would take
   always_comb begin
      new_entry.valid = 1'b1;
      if (nrpn_ff) begin
         new_entry.channel = ChannelWidth'(1)
            + ChannelWidth'(next_slot_ff[NrpnSlotBits-1:KeyWidth]);
         new_entry.key     = next_slot_ff[KeyWidth-1:0];
      end else begin
         new_entry.channel = next_channel_ff;
         new_entry.key     = '0;
      end
   end

   assign slot_free = nrpn_ff ? !next_slot_ff[NrpnSlotBits]
                              : (next_channel_ff <= ChannelWidth'(PlainChannels));

   // Allocation counters
   always_ff @(posedge clock) begin
      if (reset || cmd.counters_reset) begin
         next_channel_ff <= ChannelWidth'(1);
         next_slot_ff    <= '0;
      end else if (cmd.commit) begin
         if (nrpn_ff) begin
            next_slot_ff <= next_slot_ff + SlotWidth'(1);
         end else begin
            next_channel_ff <= next_channel_ff + ChannelWidth'(1);
         end
      end
   end

   // Clearing address
   always_ff @(posedge clock) begin
      if (reset || cmd.sweep_start) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_step) begin
         sweep_ff <= sweep_ff + EntryAddrWidth'(1);
      end
   end

   // Table write port: sweep clears, commit stores the new mapping
   assign mem_we = cmd.sweep_step || cmd.commit;
   assign mem_wa = cmd.sweep_step ? sweep_ff : elem_addr;
   assign mem_wd = cmd.sweep_step ? entry_type'('0) : new_entry;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   // Table read port, registered
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_ff <= mem[EntryAddrWidth'(req_element_index)];
      end
   end

   // Keep the fresh mapping for the forward step
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         saved_ff <= new_entry;
      end
   end

   always_comb begin
      if (cmd.from_saved) begin
         cur_entry = saved_ff;
      end else if (rd_ff.valid) begin
         cur_entry = rd_ff;
      end else begin
         cur_entry = new_entry;
      end
   end

   // Result register: strobe under reset, payload loaded on emit
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff    <= cmd.emit_kind;
         rsp_element_ff <= elem_ff;
         rsp_last_ff    <= cmd.emit_last;
         case (cmd.emit_kind)
            KIND_SETUP: begin
               rsp_channel_ff <= cur_entry.channel;
               rsp_key_ff     <= cur_entry.key;
               rsp_value_ff   <= '0;
            end
            KIND_FORWARD: begin
               rsp_channel_ff <= cur_entry.channel;
               rsp_key_ff     <= nrpn_ff ? cur_entry.key : key_ff;
               rsp_value_ff   <= value_ff;
            end
            default: begin
               rsp_channel_ff <= '0;
               rsp_key_ff     <= key_ff;
               rsp_value_ff   <= value_ff;
            end
         endcase
      end
   end

   // Status toward the controller
   always_comb begin
      status.req_map         = (req_mode == MODE_MAP);
      status.req_clear_all   = (req_mode == MODE_CLEAR_ALL);
      status.req_clear_table = (req_mode == MODE_CLEAR_TABLE);
      status.fwd_ok          = forward_enable_ff && in_range;
      status.entry_hit       = rd_ff.valid;
      status.slot_free       = slot_free;
      status.sweep_last      = (sweep_ff == EntryAddrWidth'(MaxElements - 1));
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_element_out = rsp_element_ff;
   assign rsp_channel_out = rsp_channel_ff;
   assign rsp_key_out     = rsp_key_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

### design/midi_channel_slot_allocator_unit.sv
// Mapped or dropped event: one result, registered from the lookup state; next start once back in idle.
// First use of an element: setup result, then forwarded event; busy until both are out.
// Clear modes: busy while all 1024 table entries are cleared, one per cycle; no result.
// Reset (synchronous): the same sweep of all 1024 entries with busy high; forwarding disabled.
// The table has one read and one write port; the read port is registered.
// Results show for exactly one cycle on rsp_strobe; the receiver cannot stall.
`include "midi_channel_slot_allocator_unit_assert.svh"

module midi_channel_slot_allocator_unit
   import mcsa_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [ModeWidth-1:0]    req_mode,
   input  logic [ElementWidth-1:0] req_element_index,
   input  logic                    req_is_nrpn,
   input  logic [KeyWidth-1:0]     req_key_in,
   input  logic [ValueWidth-1:0]   req_value_in,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data,
   output logic                    rsp_strobe,
   output logic [KindWidth-1:0]    rsp_kind,
   output logic [ElementWidth-1:0] rsp_element_out,
   output logic [ChannelWidth-1:0] rsp_channel_out,
   output logic [KeyWidth-1:0]     rsp_key_out,
   output logic [ValueWidth-1:0]   rsp_value_out,
   output logic                    rsp_last
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   mcsa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   mcsa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_mode          (req_mode),
      .req_element_index (req_element_index),
      .req_is_nrpn       (req_is_nrpn),
      .req_key_in        (req_key_in),
      .req_value_in      (req_value_in),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .cmd               (cmd),
      .status            (status),
      .rsp_strobe        (rsp_strobe),
      .rsp_kind          (rsp_kind),
      .rsp_element_out   (rsp_element_out),
      .rsp_channel_out   (rsp_channel_out),
      .rsp_key_out       (rsp_key_out),
      .rsp_value_out     (rsp_value_out),
      .rsp_last          (rsp_last)
   );

   // A setup result is always followed by the forwarded event of the same element
   `MCSA_ASSERT_NEXT(a_setup_then_forward, clock, reset, rsp_strobe && (rsp_kind == KIND_SETUP), rsp_strobe && (rsp_kind == KIND_FORWARD) && rsp_last && $stable(rsp_element_out), "setup not followed by forward")

   // Only a setup result leaves more to come
   `MCSA_ASSERT_SAME(a_nonlast_is_setup, clock, reset, rsp_strobe && !rsp_last, rsp_kind == KIND_SETUP, "non-final result that is not a setup")

   // Dropped events carry no channel
   `MCSA_ASSERT_SAME(a_drop_no_channel, clock, reset, rsp_strobe && (rsp_kind == KIND_DROP), rsp_channel_out == '0, "dropped result with a channel")

   // Mapped results carry a channel from 1 to 16
   `MCSA_ASSERT_SAME(a_channel_range, clock, reset, rsp_strobe && (rsp_kind != KIND_DROP), (rsp_channel_out != '0) && (rsp_channel_out <= ChannelWidth'(PlainChannels)), "mapped channel out of range")

   // A transfer in idle never yields a result in the very next cycle
   `MCSA_ASSERT_NEXT(a_no_early_result, clock, reset, start && !busy, !rsp_strobe, "result one cycle after transfer")

endmodule

### tb/sv/mcsa_checker.sv
// Result checker for the MIDI channel slot allocator: watches the request, result
// and CSR ports, keeps its own mapping table and compares every result in order.
// Depends on mcsa_pkg for field widths, modes and result kinds.
module mcsa_checker
   import mcsa_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic [ModeWidth-1:0]    req_mode,
   input  logic [ElementWidth-1:0] req_element_index,
   input  logic                    req_is_nrpn,
   input  logic [KeyWidth-1:0]     req_key_in,
   input  logic [ValueWidth-1:0]   req_value_in,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data,
   input  logic                    rsp_strobe,
   input  logic [KindWidth-1:0]    rsp_kind,
   input  logic [ElementWidth-1:0] rsp_element_out,
   input  logic [ChannelWidth-1:0] rsp_channel_out,
   input  logic [KeyWidth-1:0]     rsp_key_out,
   input  logic [ValueWidth-1:0]   rsp_value_out,
   input  logic                    rsp_last,
   output int                      fault_count,
   output int                      outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ReportLimit = 50;

   typedef struct packed {
      kind_type                kind;
      logic [ElementWidth-1:0] element;
      logic [ChannelWidth-1:0] channel;
      logic [KeyWidth-1:0]     key;
      logic [ValueWidth-1:0]   value;
      logic                    last;
   } slot_result_type;

   slot_result_type expected_results[$];

   // Shadow copy of the mapping table and allocation counters
   logic                    map_valid   [MaxElements];
   logic [ChannelWidth-1:0] map_channel [MaxElements];
   logic [KeyWidth-1:0]     map_key     [MaxElements];
   logic [ChannelWidth-1:0] plain_next;
   logic [SlotWidth-1:0]    nrpn_next;
   logic                    fwd_on;

   task automatic note_mismatch(input string msg);
      if (fault_count < ReportLimit)
         $display("[%0t] mcsa_checker: %s", $time, msg);
      fault_count++;
   endtask

   function automatic slot_result_type make_result(input kind_type kind,
         input logic [ElementWidth-1:0] element, input logic [ChannelWidth-1:0] channel,
         input logic [KeyWidth-1:0] key, input logic [ValueWidth-1:0] value,
         input logic last);
      slot_result_type r;
      r.kind    = kind;
      r.element = element;
      r.channel = channel;
      r.key     = key;
      r.value   = value;
      r.last    = last;
      return r;
   endfunction

   // Append one expectation behind the ones already waiting
   task automatic queue_result(input slot_result_type r);
      expected_results = {expected_results, r};
   endtask

   task automatic clear_mappings();
      foreach (map_valid[i])
         map_valid[i] = 1'b0;
   endtask

   // Work out the results of one transfer and advance the shadow table
   task automatic predict_event(input logic [ModeWidth-1:0] mode,
         input logic [ElementWidth-1:0] elem, input logic nrpn,
         input logic [KeyWidth-1:0] key, input logic [ValueWidth-1:0] val);
      logic room;
      room = 1'b1;
      case (mode)
         MODE_CLEAR_ALL: begin
            clear_mappings();
            plain_next = ChannelWidth'(1);
            nrpn_next  = '0;
         end
         MODE_CLEAR_TABLE: begin
            clear_mappings();
         end
         MODE_MAP: begin
            if (!fwd_on || int'(elem) >= MaxElements) begin
               queue_result(make_result(KIND_DROP, elem, '0, key, val, 1'b1));
            end else begin
               // first use: allocate a slot if one remains
               if (!map_valid[elem]) begin
                  if (nrpn)
                     room = int'(nrpn_next) < (1 << NrpnSlotBits);
                  else
                     room = int'(plain_next) <= PlainChannels;
                  if (room) begin
                     if (nrpn) begin
                        map_channel[elem] = ChannelWidth'(nrpn_next >> KeyWidth) + 1'b1;
                        map_key[elem]     = nrpn_next[KeyWidth-1:0];
                        nrpn_next         = nrpn_next + 1'b1;
                     end else begin
                        map_channel[elem] = plain_next;
                        map_key[elem]     = '0;
                        plain_next        = plain_next + 1'b1;
                     end
                     map_valid[elem] = 1'b1;
                     queue_result(make_result(KIND_SETUP, elem,
                        map_channel[elem], map_key[elem], '0, 1'b0));
                  end
               end
               if (room)
                  queue_result(make_result(KIND_FORWARD, elem,
                     map_channel[elem], nrpn ? map_key[elem] : key, val, 1'b1));
               else
                  queue_result(make_result(KIND_DROP, elem, '0, key, val, 1'b1));
            end
         end
         default: ;
      endcase
   endtask

   // Compare one result transfer with the oldest expectation
   task automatic check_result();
      slot_result_type want;
      if (expected_results.size() == 0) begin
         note_mismatch($sformatf("unexpected result kind %0d element %0d channel %0d",
            rsp_kind, rsp_element_out, rsp_channel_out));
      end else begin
         want = expected_results.pop_front();
         if (rsp_kind !== want.kind)
            note_mismatch($sformatf("element %0d: kind %0d, want %0d",
               want.element, rsp_kind, want.kind));
         if (rsp_element_out !== want.element)
            note_mismatch($sformatf("element_out %0d, want %0d",
               rsp_element_out, want.element));
         if (rsp_channel_out !== want.channel)
            note_mismatch($sformatf("element %0d: channel %0d, want %0d",
               want.element, rsp_channel_out, want.channel));
         if (rsp_key_out !== want.key)
            note_mismatch($sformatf("element %0d: key %0d, want %0d",
               want.element, rsp_key_out, want.key));
         if (rsp_value_out !== want.value)
            note_mismatch($sformatf("element %0d: value %0d, want %0d",
               want.element, rsp_value_out, want.value));
         if (rsp_last !== want.last)
            note_mismatch($sformatf("element %0d: last %0d, want %0d",
               want.element, rsp_last, want.last));
      end
   endtask

   // Results first: a result never stems from a transfer at the same edge
   always @(posedge clock) begin
      if (reset) begin
         clear_mappings();
         plain_next  = ChannelWidth'(1);
         nrpn_next   = '0;
         fwd_on      = 1'b0;
         fault_count = 0;
         expected_results.delete();
         outstanding <= 0;
      end else begin
         if (rsp_strobe)
            check_result();
         if (csr_write_enable)
            fwd_on = csr_write_data;
         if (start && !busy)
            predict_event(req_mode, req_element_index, req_is_nrpn, req_key_in,
               req_value_in);
         outstanding <= expected_results.size();
      end
   end

endmodule

### tb/sv/tb_top.sv
// Top of the MIDI channel slot allocator testbench: clock, reset, stimulus and verdict.
// Depends on mcsa_pkg, the allocator unit and mcsa_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mcsa_pkg::*;

   localparam int ClockHalf     = 5;
   localparam int ResetCycles   = 11;
   localparam int WatchdogLimit = 5000;
   localparam int DrainCycles   = 10;
   localparam int KeyMax        = (1 << KeyWidth) - 1;
   localparam int ValueMax      = (1 << ValueWidth) - 1;
   localparam logic [ModeWidth-1:0] ModeUnused = 2'd3;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [ModeWidth-1:0]    req_mode;
   logic [ElementWidth-1:0] req_element_index;
   logic                    req_is_nrpn;
   logic [KeyWidth-1:0]     req_key_in;
   logic [ValueWidth-1:0]   req_value_in;
   logic                    csr_write_enable;
   logic                    csr_write_data;
   logic                    rsp_strobe;
   logic [KindWidth-1:0]    rsp_kind;
   logic [ElementWidth-1:0] rsp_element_out;
   logic [ChannelWidth-1:0] rsp_channel_out;
   logic [KeyWidth-1:0]     rsp_key_out;
   logic [ValueWidth-1:0]   rsp_value_out;
   logic                    rsp_last;
   int                      fault_count;
   int                      outstanding;
   logic                    gaps_on = 1'b0;
   int                      stall_cycles = 0;

   always #ClockHalf clock = ~clock;

   midi_channel_slot_allocator_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_element_index (req_element_index),
      .req_is_nrpn       (req_is_nrpn),
      .req_key_in        (req_key_in),
      .req_value_in      (req_value_in),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_kind          (rsp_kind),
      .rsp_element_out   (rsp_element_out),
      .rsp_channel_out   (rsp_channel_out),
      .rsp_key_out       (rsp_key_out),
      .rsp_value_out     (rsp_value_out),
      .rsp_last          (rsp_last)
   );

   mcsa_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_element_index (req_element_index),
      .req_is_nrpn       (req_is_nrpn),
      .req_key_in        (req_key_in),
      .req_value_in      (req_value_in),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_kind          (rsp_kind),
      .rsp_element_out   (rsp_element_out),
      .rsp_channel_out   (rsp_channel_out),
      .rsp_key_out       (rsp_key_out),
      .rsp_value_out     (rsp_value_out),
      .rsp_last          (rsp_last),
      .fault_count       (fault_count),
      .outstanding       (outstanding)
   );

   // Abort when nothing has moved on any port for too long
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || csr_write_enable) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
         $display("** midi_channel_slot_allocator_unit: FAILED **");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Drive one request and hold it until the transfer; idle at random cycles when gaps are on
   task automatic send_event(input logic [ModeWidth-1:0] mode,
         input logic [ElementWidth-1:0] elem, input logic nrpn,
         input logic [KeyWidth-1:0] key, input logic [ValueWidth-1:0] val);
      req_mode          <= mode;
      req_element_index <= elem;
      req_is_nrpn       <= nrpn;
      req_key_in        <= key;
      req_value_in      <= val;
      do begin
         start <= (gaps_on && ($urandom_range(0, 99) < 30)) ? 1'b0 : 1'b1;
         @(posedge clock);
      end while (!start || busy);
   endtask

   // Change forwarding once all results are in and the block has gone quiet
   task automatic write_forward(input logic on);
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= on;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Favor a small pool of elements so mappings get reused
   function automatic logic [ElementWidth-1:0] pick_element();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5)
         return ElementWidth'($urandom_range(0, 23));
      else if (sel == 5)
         return $urandom_range(0, 1) ? ElementWidth'(MaxElements - 1) : '0;
      else
         return ElementWidth'($urandom_range(0, MaxElements - 1));
   endfunction

   task automatic random_phase(input int n_events, input int quiet_events);
      int done;
      int pick;
      logic [ModeWidth-1:0] mode;
      done = 0;
      while (done < n_events) begin
         gaps_on = (done >= quiet_events);
         pick = $urandom_range(0, 99);
         if (pick < 3)
            mode = MODE_CLEAR_ALL;
         else if (pick < 6)
            mode = MODE_CLEAR_TABLE;
         else if (pick < 8)
            mode = ModeUnused;
         else
            mode = MODE_MAP;
         send_event(mode, pick_element(), 1'($urandom_range(0, 1)),
            KeyWidth'($urandom_range(0, KeyMax)), ValueWidth'($urandom_range(0, ValueMax)));
         if (mode == MODE_MAP)
            done++;
      end
      gaps_on = 1'b0;
   endtask

   task automatic run_directed();
      // forwarding still off after reset: drops, ignored mode, clear
      send_event(MODE_MAP, 10'd5, 1'b0, KeyWidth'(KeyMax), ValueWidth'(ValueMax));
      send_event(MODE_MAP, ElementWidth'(MaxElements - 1), 1'b1, '0, '0);
      send_event(ModeUnused, 10'd3, 1'b1, 14'd7, 14'd9);
      send_event(MODE_CLEAR_ALL, '0, 1'b0, '0, '0);
      write_forward(1'b1);
      // element 0 mapped plain, then reused by both event types
      send_event(MODE_MAP, '0, 1'b0, '0, '0);
      send_event(MODE_MAP, '0, 1'b0, KeyWidth'(KeyMax), ValueWidth'(ValueMax));
      send_event(MODE_MAP, '0, 1'b1, 14'h1555, 14'h2AAA);
      // top element mapped NRPN, then a plain event on it
      send_event(MODE_MAP, ElementWidth'(MaxElements - 1), 1'b1, 14'h2AAA, 14'h1555);
      send_event(MODE_MAP, ElementWidth'(MaxElements - 1), 1'b0, 14'h3C3C, 14'h0F0F);
      // use up the plain channels, then one past the end
      for (int e = 1; e <= PlainChannels; e++)
         send_event(MODE_MAP, ElementWidth'(e), 1'b0, KeyWidth'(e), ValueWidth'(e));
      // table clear keeps the counters: plain stays exhausted, NRPN continues
      send_event(MODE_CLEAR_TABLE, '0, 1'b0, '0, '0);
      send_event(MODE_MAP, '0, 1'b0, 14'd100, 14'd200);
      send_event(MODE_MAP, '0, 1'b1, 14'd300, 14'd400);
   endtask

   initial begin
      reset             <= 1'b1;
      start             <= 1'b0;
      req_mode          <= MODE_MAP;
      req_element_index <= '0;
      req_is_nrpn       <= 1'b0;
      req_key_in        <= '0;
      req_value_in      <= '0;
      csr_write_enable  <= 1'b0;
      csr_write_data    <= 1'b0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      // wait out the table sweep that follows reset
      do @(posedge clock); while (busy);

      run_directed();
      random_phase(400, 150);
      write_forward(1'b0);
      random_phase(100, 0);
      write_forward(1'b1);
      random_phase(300, 0);

      // drain the remaining results, then give the verdict
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DrainCycles) @(posedge clock);
      if (fault_count == 0)
         $display("** midi_channel_slot_allocator_unit: PASSED **");
      else
         $display("** midi_channel_slot_allocator_unit: FAILED **");
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/mcsa_pkg.sv
design/mcsa_ctrl.sv
design/mcsa_datapath.sv
design/midi_channel_slot_allocator_unit.sv
tb/sv/mcsa_checker.sv
tb/sv/tb_top.sv
